/* design/hwtw_pkg.sv */
// Shared types and constants for the hierarchical timer wheel.
package hwtw_pkg;

    // Field widths of the stream payloads
    localparam int ID_W       = 6;
    localparam int EXP_W      = 64;
    localparam int ACT_W      = 2;
    localparam int ERR_W      = 2;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;
    localparam int NUM_LEVELS = 4;
    localparam int LVL_SEL_W  = 2;

    // Distances below 2^FAR_BITS still land in the top level
    localparam int FAR_BITS = 32;

    // Request actions as carried on the input tuser
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd3;

    // Result error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_PENDING = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PARKED  = 2'd2;

    typedef enum logic [2:0] {
        KIND_ADD,
        KIND_MOD,
        KIND_DEL,
        KIND_TICK,
        KIND_BAD
    } req_kind_t;

    typedef struct packed {
        req_kind_t         kind;
        logic [ID_W-1:0]   id;
        logic [EXP_W-1:0]  expires;
    } req_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UN_RD,
        ST_UN_WR,
        ST_PL_DIFF,
        ST_PL_CLS,
        ST_LK_A,
        ST_LK_B,
        ST_CA_START,
        ST_CA_LOAD,
        ST_CA_TEST,
        ST_CA_NX,
        ST_CA_STEP,
        ST_FI_RD,
        ST_FI_HD,
        ST_FI_WR,
        ST_EMIT
    } back_state_t;

endpackage

/* design/hierarchical_timer_wheel.sv */
// Top level of the hierarchical timer wheel.
// Five-level timing wheel for TIMER_SLOTS timers: a root level of 2^ROOT_BITS
// buckets and four levels of 2^LEVEL_BITS buckets, each bucket a linked list
// held in on-chip memories. After reset the block sweeps the bucket heads
// (2^ROOT_BITS + 4*2^LEVEL_BITS of them, 512 at the defaults) with s_tready low.
// Requests pass through a two-entry queue to a single sequencer, so one
// request is worked at a time.
// A tick fires every timer in the root bucket; when the root index is 0 it
// first cascades the level buckets, replacing each timer moved.
// Results leave through a registered output.
module hierarchical_timer_wheel
    import hwtw_pkg::*;
#(
    parameter int TIMER_SLOTS = 64,
    parameter int ROOT_BITS   = 8,
    parameter int LEVEL_BITS  = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // timer_id[5:0], expires[69:6], pad
    input  logic [ACT_W-1:0]     s_tuser,   // action[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // was_pending[0], error_code[2:1],
                                            // fired_id[8:3], pad
    output logic                 m_tuser,   // fired_valid
    output logic                 m_tlast    // last
);

    logic clr_done;
    logic push_valid, push_ready;
    req_t push_req;
    logic pop_valid, pop_ready;
    req_t pop_req;

    hwtw_front #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clr_done   (clr_done),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    hwtw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    hwtw_back #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .ROOT_BITS   (ROOT_BITS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_req    (pop_req),
        .q_pop    (pop_ready),
        .clr_done (clr_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/hwtw_front.sv */
// Front end: accepts input requests and classifies them for the queue.
module hwtw_front
    import hwtw_pkg::*;
#(
    parameter int TIMER_SLOTS = 64
)
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // timer_id, expires, zero pad
    input  logic [ACT_W-1:0]     s_tuser,    // action
    input  logic                 clr_done,
    output logic                 push_valid,
    input  logic                 push_ready,
    output req_t                 push_req
);

    logic [ID_W-1:0]  in_id;
    logic [EXP_W-1:0] in_exp;
    logic             id_ok;

    // Unpack the payload
    assign in_id  = s_tdata[ID_W-1:0];
    assign in_exp = s_tdata[ID_W +: EXP_W];
    assign id_ok  = ({1'b0, in_id} < (ID_W+1)'(TIMER_SLOTS));

    // Hold off requests until the bucket heads are cleared
    assign s_tready   = push_ready && clr_done;
    assign push_valid = s_tvalid && clr_done;

    // Classify the request
    always_comb
    begin
        push_req.id      = in_id;
        push_req.expires = in_exp;
        case (s_tuser)
            ACT_TICK:   push_req.kind = KIND_TICK;
            ACT_ADD:    push_req.kind = id_ok ? KIND_ADD : KIND_BAD;
            ACT_MODIFY: push_req.kind = id_ok ? KIND_MOD : KIND_BAD;
            ACT_DELETE: push_req.kind = id_ok ? KIND_DEL : KIND_BAD;
            default:    push_req.kind = KIND_BAD;
        endcase
    end

endmodule

/* design/hwtw_queue.sv */
// Two-entry request queue between the front end and the sequencer.
module hwtw_queue
    import hwtw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  req_t push_req,
    output logic pop_valid,
    input  logic pop_ready,
    output req_t pop_req
);

    localparam int DEPTH = 2;

    req_t       entry_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_req    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* design/hwtw_back.sv */
// Sequencer: bucket lists, timer slots, cascade and fire walks, result register.
module hwtw_back
    import hwtw_pkg::*;
#(
    parameter int TIMER_SLOTS = 64,
    parameter int ROOT_BITS   = 8,
    parameter int LEVEL_BITS  = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  req_t                 q_req,
    output logic                 q_pop,
    output logic                 clr_done,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int RS      = 1 << ROOT_BITS;
    localparam int LS      = 1 << LEVEL_BITS;
    localparam int NB      = RS + NUM_LEVELS * LS;
    localparam int BKT_W   = $clog2(NB + 1);
    localparam int BKT_IW  = $clog2(NB);
    localparam int PTR_W   = $clog2(TIMER_SLOTS + 1);
    localparam int SLOT_IW = $clog2(TIMER_SLOTS);

    localparam logic [PTR_W-1:0] NIL       = PTR_W'(TIMER_SLOTS);
    localparam logic [BKT_W-1:0] NO_BUCKET = BKT_W'(NB);

    // Bucket and slot memories
    logic [PTR_W-1:0] head_mem [NB];
    logic [PTR_W-1:0] tail_mem [NB];
    logic [PTR_W-1:0] next_mem [TIMER_SLOTS];
    logic [PTR_W-1:0] prev_mem [TIMER_SLOTS];
    logic [BKT_W-1:0] bkt_mem  [TIMER_SLOTS];
    logic [EXP_W-1:0] exp_mem  [TIMER_SLOTS];

    logic [PTR_W-1:0] head_rd_reg, tail_rd_reg, next_rd_reg, prev_rd_reg;
    logic [BKT_W-1:0] bkt_rd_reg;
    logic [EXP_W-1:0] exp_rd_reg;

    logic               head_we, tail_we, next_we, prev_we, bkt_we, exp_we;
    logic [BKT_IW-1:0]  head_waddr, head_raddr, tail_waddr, tail_raddr;
    logic [SLOT_IW-1:0] next_waddr, next_raddr, prev_waddr, prev_raddr;
    logic [SLOT_IW-1:0] bkt_waddr, bkt_raddr, exp_waddr, exp_raddr;
    logic [PTR_W-1:0]   head_wdata, tail_wdata, next_wdata, prev_wdata;
    logic [BKT_W-1:0]   bkt_wdata;
    logic [EXP_W-1:0]   exp_wdata;

    // Pending flags
    logic               pend_reg [TIMER_SLOTS];
    logic               pend_we, pend_val;
    logic [SLOT_IW-1:0] pend_idx;

    back_state_t state_reg, state_next;

    req_kind_t          req_kind_reg, req_kind_next;
    logic [SLOT_IW-1:0] req_id_reg, req_id_next;
    logic               was_reg, was_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [SLOT_IW-1:0] place_id_reg, place_id_next;
    logic [EXP_W-1:0]   place_exp_reg, place_exp_next;
    logic [EXP_W-1:0]   diff_reg, diff_next;
    logic [BKT_IW-1:0]  place_bkt_reg, place_bkt_next;
    logic [PTR_W-1:0]   cur_reg, cur_next;
    logic [PTR_W-1:0]   nx_reg, nx_next;
    logic [LVL_SEL_W-1:0] casc_lvl_reg, casc_lvl_next;
    logic [EXP_W-1:0]   tick_reg, tick_next;
    logic [ROOT_BITS-1:0] root_idx_reg, root_idx_next;
    logic [LEVEL_BITS-1:0] lvl_idx_reg [NUM_LEVELS];
    logic [LEVEL_BITS-1:0] lvl_idx_next [NUM_LEVELS];
    logic [BKT_IW-1:0]  clr_cnt_reg, clr_cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_was_reg, out_was_next;
    logic [ERR_W-1:0]   out_err_reg, out_err_next;
    logic               out_fv_reg, out_fv_next;
    logic [ID_W-1:0]    out_fid_reg, out_fid_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               q_pend;
    logic               cls_parked;
    logic [BKT_IW-1:0]  cls_bkt;
    logic [BKT_IW-1:0]  casc_bkt;
    logic [BKT_IW-1:0]  root_bkt;
    logic [PTR_W-1:0]   nx_adj;
    logic               head_empty;
    logic               next_nil;
    back_state_t        ret_state;

    assign out_free   = !out_valid_reg || m_tready;
    assign q_pend     = pend_reg[q_req.id[SLOT_IW-1:0]];
    assign casc_bkt   = BKT_IW'(RS) + (BKT_IW'(casc_lvl_reg) << LEVEL_BITS)
                        + BKT_IW'(lvl_idx_reg[casc_lvl_reg]);
    assign root_bkt   = BKT_IW'(root_idx_reg);
    assign nx_adj     = (nx_reg < NIL) ? nx_reg : NIL;
    assign head_empty = (head_rd_reg >= NIL);
    assign next_nil   = (next_rd_reg >= NIL);
    assign ret_state  = (req_kind_reg == KIND_TICK) ? ST_CA_TEST : ST_EMIT;
    assign clr_done   = (state_reg != ST_CLEAR);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-ID_W-ERR_W-1)'(0), out_fid_reg, out_err_reg, out_was_reg};
    assign m_tuser  = out_fv_reg;
    assign m_tlast  = out_last_reg;

    // Choose a bucket from the distance to expiry
    always_comb
    begin
        cls_parked = 1'b0;
        if (diff_reg[EXP_W-1:ROOT_BITS] == '0)
        begin
            cls_bkt = BKT_IW'(place_exp_reg[ROOT_BITS-1:0]);
        end
        else if (diff_reg[EXP_W-1:ROOT_BITS+LEVEL_BITS] == '0)
        begin
            cls_bkt = BKT_IW'(RS) + BKT_IW'(place_exp_reg[ROOT_BITS +: LEVEL_BITS]);
        end
        else if (diff_reg[EXP_W-1:ROOT_BITS+2*LEVEL_BITS] == '0)
        begin
            cls_bkt = BKT_IW'(RS + LS)
                      + BKT_IW'(place_exp_reg[ROOT_BITS+LEVEL_BITS +: LEVEL_BITS]);
        end
        else if (diff_reg[EXP_W-1:ROOT_BITS+3*LEVEL_BITS] == '0)
        begin
            cls_bkt = BKT_IW'(RS + 2*LS)
                      + BKT_IW'(place_exp_reg[ROOT_BITS+2*LEVEL_BITS +: LEVEL_BITS]);
        end
        else if (diff_reg[EXP_W-1])
        begin
            cls_bkt = root_bkt;
        end
        else if (diff_reg[EXP_W-1:FAR_BITS] == '0)
        begin
            cls_bkt = BKT_IW'(RS + 3*LS)
                      + BKT_IW'(place_exp_reg[ROOT_BITS+3*LEVEL_BITS +: LEVEL_BITS]);
        end
        else
        begin
            cls_bkt    = '0;
            cls_parked = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BKT_IW'(NB - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_req.kind)
                        KIND_ADD:  state_next = q_pend ? ST_EMIT : ST_PL_DIFF;
                        KIND_MOD:  state_next = q_pend ? ST_UN_RD : ST_PL_DIFF;
                        KIND_DEL:  state_next = q_pend ? ST_UN_RD : ST_EMIT;
                        KIND_TICK: state_next = (root_idx_reg == '0) ? ST_CA_START
                                                                      : ST_FI_RD;
                        default:   state_next = ST_EMIT;
                    endcase
                end
            end
            ST_UN_RD:    state_next = ST_UN_WR;
            ST_UN_WR:    state_next = (req_kind_reg == KIND_MOD) ? ST_PL_DIFF : ST_EMIT;
            ST_PL_DIFF:  state_next = ST_PL_CLS;
            ST_PL_CLS:   state_next = cls_parked ? ret_state : ST_LK_A;
            ST_LK_A:     state_next = head_empty ? ret_state : ST_LK_B;
            ST_LK_B:     state_next = ret_state;
            ST_CA_START: state_next = ST_CA_LOAD;
            ST_CA_LOAD:  state_next = ST_CA_TEST;
            ST_CA_TEST:  state_next = (cur_reg < NIL) ? ST_CA_NX : ST_CA_STEP;
            ST_CA_NX:    state_next = ST_PL_DIFF;
            ST_CA_STEP:
            begin
                if (lvl_idx_reg[casc_lvl_reg] == '0
                    && casc_lvl_reg != LVL_SEL_W'(NUM_LEVELS - 1))
                    state_next = ST_CA_START;
                else
                    state_next = ST_FI_RD;
            end
            ST_FI_RD:    state_next = ST_FI_HD;
            ST_FI_HD:    state_next = head_empty ? ST_EMIT : ST_FI_WR;
            ST_FI_WR:
            begin
                if (out_free)
                    state_next = next_nil ? ST_IDLE : ST_FI_RD;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
        tail_we = 1'b0; tail_waddr = '0; tail_wdata = '0; tail_raddr = '0;
        next_we = 1'b0; next_waddr = '0; next_wdata = '0; next_raddr = '0;
        prev_we = 1'b0; prev_waddr = '0; prev_wdata = '0; prev_raddr = '0;
        bkt_we  = 1'b0; bkt_waddr  = '0; bkt_wdata  = '0; bkt_raddr  = '0;
        exp_we  = 1'b0; exp_waddr  = '0; exp_wdata  = '0; exp_raddr  = '0;
        pend_we = 1'b0; pend_idx   = req_id_reg;        pend_val   = 1'b0;
        q_pop   = 1'b0;

        req_kind_next  = req_kind_reg;
        req_id_next    = req_id_reg;
        was_next       = was_reg;
        err_next       = err_reg;
        place_id_next  = place_id_reg;
        place_exp_next = place_exp_reg;
        diff_next      = diff_reg;
        place_bkt_next = place_bkt_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        casc_lvl_next  = casc_lvl_reg;
        tick_next      = tick_reg;
        root_idx_next  = root_idx_reg;
        lvl_idx_next   = lvl_idx_reg;
        clr_cnt_next   = clr_cnt_reg;

        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_was_next   = out_was_reg;
        out_err_next   = out_err_reg;
        out_fv_next    = out_fv_reg;
        out_fid_next   = out_fid_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            // Sweep every bucket head to empty
            ST_CLEAR:
            begin
                head_we      = 1'b1;
                head_waddr   = clr_cnt_reg;
                head_wdata   = NIL;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end

            // Take a request and settle the pending flag
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    req_kind_next  = q_req.kind;
                    req_id_next    = q_req.id[SLOT_IW-1:0];
                    place_id_next  = q_req.id[SLOT_IW-1:0];
                    place_exp_next = q_req.expires;
                    was_next       = 1'b0;
                    err_next       = ERR_NONE;
                    casc_lvl_next  = '0;
                    pend_idx       = q_req.id[SLOT_IW-1:0];
                    exp_waddr      = q_req.id[SLOT_IW-1:0];
                    exp_wdata      = q_req.expires;
                    case (q_req.kind)
                        KIND_ADD:
                        begin
                            was_next = q_pend;
                            if (q_pend)
                            begin
                                err_next = ERR_PENDING;
                            end
                            else
                            begin
                                exp_we   = 1'b1;
                                pend_we  = 1'b1;
                                pend_val = 1'b1;
                            end
                        end
                        KIND_MOD:
                        begin
                            was_next = q_pend;
                            exp_we   = 1'b1;
                            pend_we  = 1'b1;
                            pend_val = 1'b1;
                        end
                        KIND_DEL:
                        begin
                            was_next = q_pend;
                            pend_we  = 1'b1;
                            pend_val = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Unlink the timer from its bucket
            ST_UN_RD:
            begin
                next_raddr = req_id_reg;
                prev_raddr = req_id_reg;
                bkt_raddr  = req_id_reg;
            end
            ST_UN_WR:
            begin
                if (bkt_rd_reg < NO_BUCKET)
                begin
                    if (prev_rd_reg >= NIL)
                    begin
                        head_we    = 1'b1;
                        head_waddr = bkt_rd_reg[BKT_IW-1:0];
                        head_wdata = next_rd_reg;
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd_reg[SLOT_IW-1:0];
                        next_wdata = next_rd_reg;
                    end
                    if (next_nil)
                    begin
                        tail_we    = 1'b1;
                        tail_waddr = bkt_rd_reg[BKT_IW-1:0];
                        tail_wdata = prev_rd_reg;
                    end
                    else
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rd_reg[SLOT_IW-1:0];
                        prev_wdata = prev_rd_reg;
                    end
                    bkt_we    = 1'b1;
                    bkt_waddr = req_id_reg;
                    bkt_wdata = NO_BUCKET;
                end
            end

            // Place: distance, then bucket choice
            ST_PL_DIFF:
            begin
                diff_next = place_exp_reg - tick_reg;
            end
            ST_PL_CLS:
            begin
                if (cls_parked)
                begin
                    bkt_we    = 1'b1;
                    bkt_waddr = place_id_reg;
                    bkt_wdata = NO_BUCKET;
                    if (req_kind_reg == KIND_TICK)
                        cur_next = nx_adj;
                    else
                        err_next = ERR_PARKED;
                end
                else
                begin
                    place_bkt_next = cls_bkt;
                    head_raddr     = cls_bkt;
                    tail_raddr     = cls_bkt;
                end
            end

            // Link at the tail of the bucket
            ST_LK_A:
            begin
                // Hold the old tail for the second link step
                tail_raddr = place_bkt_reg;
                next_we    = 1'b1;
                next_waddr = place_id_reg;
                next_wdata = NIL;
                prev_we    = 1'b1;
                prev_waddr = place_id_reg;
                prev_wdata = head_empty ? NIL : tail_rd_reg;
                bkt_we     = 1'b1;
                bkt_waddr  = place_id_reg;
                bkt_wdata  = BKT_W'(place_bkt_reg);
                tail_we    = 1'b1;
                tail_waddr = place_bkt_reg;
                tail_wdata = PTR_W'(place_id_reg);
                if (head_empty)
                begin
                    head_we    = 1'b1;
                    head_waddr = place_bkt_reg;
                    head_wdata = PTR_W'(place_id_reg);
                    if (req_kind_reg == KIND_TICK)
                        cur_next = nx_adj;
                end
            end
            ST_LK_B:
            begin
                next_we    = 1'b1;
                next_waddr = tail_rd_reg[SLOT_IW-1:0];
                next_wdata = PTR_W'(place_id_reg);
                if (req_kind_reg == KIND_TICK)
                    cur_next = nx_adj;
            end

            // Cascade: detach the level bucket and replace each timer
            ST_CA_START:
            begin
                head_raddr = casc_bkt;
                head_we    = 1'b1;
                head_waddr = casc_bkt;
                head_wdata = NIL;
            end
            ST_CA_LOAD:
            begin
                cur_next = head_rd_reg;
            end
            ST_CA_TEST:
            begin
                next_raddr    = cur_reg[SLOT_IW-1:0];
                exp_raddr     = cur_reg[SLOT_IW-1:0];
                place_id_next = cur_reg[SLOT_IW-1:0];
            end
            ST_CA_NX:
            begin
                nx_next        = next_rd_reg;
                place_exp_next = exp_rd_reg;
            end
            ST_CA_STEP:
            begin
                lvl_idx_next[casc_lvl_reg] = lvl_idx_reg[casc_lvl_reg] + 1'b1;
                casc_lvl_next              = casc_lvl_reg + 1'b1;
            end

            // Fire: pop the root bucket head one timer at a time
            ST_FI_RD:
            begin
                head_raddr = root_bkt;
            end
            ST_FI_HD:
            begin
                next_raddr    = head_rd_reg[SLOT_IW-1:0];
                place_id_next = head_rd_reg[SLOT_IW-1:0];
            end
            ST_FI_WR:
            begin
                // Keep the successor read stable while the sink stalls
                next_raddr = place_id_reg;
                if (out_free)
                begin
                    head_we    = 1'b1;
                    head_waddr = root_bkt;
                    head_wdata = next_rd_reg;
                    if (next_nil)
                    begin
                        tail_we    = 1'b1;
                        tail_waddr = root_bkt;
                        tail_wdata = NIL;
                        tick_next     = tick_reg + 1'b1;
                        root_idx_next = root_idx_reg + 1'b1;
                    end
                    else
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rd_reg[SLOT_IW-1:0];
                        prev_wdata = NIL;
                    end
                    bkt_we    = 1'b1;
                    bkt_waddr = place_id_reg;
                    bkt_wdata = NO_BUCKET;
                    pend_we   = 1'b1;
                    pend_idx  = place_id_reg;
                    pend_val  = 1'b0;
                    out_valid_next = 1'b1;
                    out_was_next   = 1'b0;
                    out_err_next   = ERR_NONE;
                    out_fv_next    = 1'b1;
                    out_fid_next   = ID_W'(place_id_reg);
                    out_last_next  = next_nil;
                end
            end

            // Single result for the request
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_was_next   = was_reg;
                    out_err_next   = err_reg;
                    out_fv_next    = 1'b0;
                    out_fid_next   = '0;
                    out_last_next  = 1'b1;
                    if (req_kind_reg == KIND_TICK)
                    begin
                        tick_next     = tick_reg + 1'b1;
                        root_idx_next = root_idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            tick_reg      <= '0;
            root_idx_reg  <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
                lvl_idx_reg[i] <= '0;
            out_valid_reg <= 1'b0;
            req_kind_reg  <= KIND_BAD;
            casc_lvl_reg  <= '0;
            for (int i = 0; i < TIMER_SLOTS; i++)
                pend_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tick_reg      <= tick_next;
            root_idx_reg  <= root_idx_next;
            lvl_idx_reg   <= lvl_idx_next;
            out_valid_reg <= out_valid_next;
            req_kind_reg  <= req_kind_next;
            casc_lvl_reg  <= casc_lvl_next;
            if (pend_we)
                pend_reg[pend_idx] <= pend_val;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_id_reg    <= req_id_next;
        was_reg       <= was_next;
        err_reg       <= err_next;
        place_id_reg  <= place_id_next;
        place_exp_reg <= place_exp_next;
        diff_reg      <= diff_next;
        place_bkt_reg <= place_bkt_next;
        cur_reg       <= cur_next;
        nx_reg        <= nx_next;
        out_was_reg   <= out_was_next;
        out_err_reg   <= out_err_next;
        out_fv_reg    <= out_fv_next;
        out_fid_reg   <= out_fid_next;
        out_last_reg  <= out_last_next;
    end

    // Memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rd_reg <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
            tail_mem[tail_waddr] <= tail_wdata;
        tail_rd_reg <= tail_mem[tail_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        next_rd_reg <= next_mem[next_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        prev_rd_reg <= prev_mem[prev_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_waddr] <= bkt_wdata;
        bkt_rd_reg <= bkt_mem[bkt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
            exp_mem[exp_waddr] <= exp_wdata;
        exp_rd_reg <= exp_mem[exp_raddr];
    end

endmodule

/* design/hwtw_checker.sv */
// Port-level checks for the hierarchical timer wheel, bound to the top level.
module hwtw_checker
    import hwtw_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [ACT_W-1:0]     s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

    // Only fired timers may leave a request's results open
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser)
    else $error("non-final result without a fired timer");

    // A fired timer carries no status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[2:0] == 3'd0)
    else $error("fired result carries status");

    // A refused add always reports the timer as pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:1] == ERR_PENDING |-> m_tdata[0] && !m_tuser)
    else $error("refused add without pending flag");

endmodule

bind hierarchical_timer_wheel hwtw_checker u_hwtw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
